// ===== hw/rtl/lsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrc_pkg
// Types and constants shared by the line segment rectangle clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  // Width of every coordinate, bound and input or result field.
  localparam int unsigned CoordWidth = 16;
  // Width of a difference of two coordinates and of its magnitude.
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  // Width of a product of two magnitudes.
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  // Width of a crossing value before it is known to lie in the window.
  localparam int unsigned SolWidth   = CoordWidth + 3;
  // Width of a Manhattan distance between two points.
  localparam int unsigned DistWidth  = CoordWidth + 2;
  // Number of window edges, one divider lane each.
  localparam int unsigned NumEdges   = 4;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic [DiffWidth-1:0]         mag_t;
  typedef logic [ProdWidth-1:0]         prod_t;
  typedef logic signed [SolWidth-1:0]   sol_t;
  typedef logic [DistWidth-1:0]         dist_t;

  typedef enum logic [1:0] {
    CfgLeft   = 2'd0,
    CfgRight  = 2'd1,
    CfgTop    = 2'd2,
    CfgBottom = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   visible;
    logic   was_clipped;
    coord_t out_start_x;
    coord_t out_start_y;
    coord_t out_end_x;
    coord_t out_end_y;
  } out_item_t;

  // Normalised clip window, low bound never above high bound.
  typedef struct packed {
    coord_t xlo;
    coord_t xhi;
    coord_t ylo;
    coord_t yhi;
  } window_t;

  // Item data that travels alongside the divider lanes.
  typedef struct packed {
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    window_t               win;
    logic                  in0;
    logic                  in1;
    logic [NumEdges-1:0]   ok;
    logic [NumEdges-1:0]   neg;
  } side_t;

  // Operands of one divider lane.
  typedef struct packed {
    prod_t prod;
    mag_t  den;
  } lane_t;

  // Result of one divider lane.
  typedef struct packed {
    mag_t quo;
    logic frac;
  } quot_t;

  function automatic mag_t mag_of(diff_t v);
    mag_of = v[DiffWidth-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

// ===== hw/rtl/lsrc_setup.sv =====
// ----------------------------------------------------------------------------
// lsrc_setup
// Forms the edge tests, operand magnitudes and products for every window edge.
// ----------------------------------------------------------------------------
module lsrc_setup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  lsrc_pkg::in_item_t                  item_i,
  input  lsrc_pkg::window_t                   win_i,
  output logic                                valid_o,
  output lsrc_pkg::side_t                     side_o,
  output lsrc_pkg::lane_t [lsrc_pkg::NumEdges-1:0] lane_o
);

  localparam int unsigned CW = lsrc_pkg::CoordWidth;

  lsrc_pkg::side_t side_d, side1_q, side2_q;
  lsrc_pkg::mag_t  amag_d [lsrc_pkg::NumEdges];
  lsrc_pkg::mag_t  bmag_d [lsrc_pkg::NumEdges];
  lsrc_pkg::mag_t  dmag_d [lsrc_pkg::NumEdges];
  lsrc_pkg::mag_t  amag_q [lsrc_pkg::NumEdges];
  lsrc_pkg::mag_t  bmag_q [lsrc_pkg::NumEdges];
  lsrc_pkg::mag_t  dmag_q [lsrc_pkg::NumEdges];
  lsrc_pkg::lane_t [lsrc_pkg::NumEdges-1:0] lane_q;
  logic            valid1_q, valid2_q;

  always_comb begin
    lsrc_pkg::coord_t x0, y0, x1, y1, p0, p1, edge_c, pmin, pmax;
    lsrc_pkg::diff_t  dx, dy, dd, bb, aa;
    x0 = item_i.start_x;
    y0 = item_i.start_y;
    x1 = item_i.end_x;
    y1 = item_i.end_y;
    dx = {x1[CW-1], x1} - {x0[CW-1], x0};
    dy = {y1[CW-1], y1} - {y0[CW-1], y0};
    side_d.x0  = x0;
    side_d.y0  = y0;
    side_d.x1  = x1;
    side_d.y1  = y1;
    side_d.win = win_i;
    side_d.in0 = (x0 >= win_i.xlo) && (x0 <= win_i.xhi) &&
                 (y0 >= win_i.ylo) && (y0 <= win_i.yhi);
    side_d.in1 = (x1 >= win_i.xlo) && (x1 <= win_i.xhi) &&
                 (y1 >= win_i.ylo) && (y1 <= win_i.yhi);
    side_d.ok  = '0;
    side_d.neg = '0;
    for (int k = 0; k < lsrc_pkg::NumEdges; k++) begin
      // The left and right edges are vertical (x bounds), top and bottom horizontal.
      if (k < 2) begin
        p0 = x0; p1 = x1; dd = dx; bb = dy;
        edge_c = (k == 0) ? win_i.xlo : win_i.xhi;
      end else begin
        p0 = y0; p1 = y1; dd = dy; bb = dx;
        edge_c = (k == 2) ? win_i.ylo : win_i.yhi;
      end
      pmin = (p0 < p1) ? p0 : p1;
      pmax = (p0 < p1) ? p1 : p0;
      side_d.ok[k] = (dd != '0) && (edge_c >= pmin) && (edge_c <= pmax);
      // An edge out of reach divides zero by one, keeping the quotient small.
      if (side_d.ok[k]) begin
        aa = {edge_c[CW-1], edge_c} - {p0[CW-1], p0};
      end else begin
        aa = '0;
        dd = lsrc_pkg::diff_t'(1);
      end
      side_d.neg[k] = aa[CW] ^ bb[CW] ^ dd[CW];
      amag_d[k] = lsrc_pkg::mag_of(aa);
      bmag_d[k] = lsrc_pkg::mag_of(bb);
      dmag_d[k] = lsrc_pkg::mag_of(dd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side_d;
    side2_q <= side1_q;
    for (int k = 0; k < lsrc_pkg::NumEdges; k++) begin
      amag_q[k]      <= amag_d[k];
      bmag_q[k]      <= bmag_d[k];
      dmag_q[k]      <= dmag_d[k];
      lane_q[k].prod <= lsrc_pkg::prod_t'(amag_q[k]) * lsrc_pkg::prod_t'(bmag_q[k]);
      lane_q[k].den  <= dmag_q[k];
    end
  end

  assign valid_o = valid2_q;
  assign side_o  = side2_q;
  assign lane_o  = lane_q;

endmodule

// ===== hw/rtl/lsrc_div.sv =====
// ----------------------------------------------------------------------------
// lsrc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsrc_div (
  input  logic            clk_i,
  input  lsrc_pkg::lane_t lane_i,
  output lsrc_pkg::quot_t quot_o
);

  localparam int unsigned DW = lsrc_pkg::DiffWidth;

  // The quotient is known to fit DW bits, so the upper half starts as the
  // partial remainder and the lower half is shifted in one bit per stage.
  logic [DW-1:0] rem_c [DW];
  logic [DW-1:0] low_c [DW];
  logic [DW-1:0] quo_c [DW];
  logic [DW-1:0] den_c [DW];
  logic [DW-1:0] rem_d [DW];
  logic [DW-1:0] quo_d [DW];
  logic [DW-1:0] rem_q [DW];
  logic [DW-1:0] low_q [DW];
  logic [DW-1:0] quo_q [DW];
  logic [DW-1:0] den_q [DW];

  always_comb begin
    logic [DW:0] trial, diff;
    rem_c[0] = lane_i.prod[2*DW-1:DW];
    low_c[0] = lane_i.prod[DW-1:0];
    quo_c[0] = '0;
    den_c[0] = lane_i.den;
    for (int s = 1; s < DW; s++) begin
      rem_c[s] = rem_q[s-1];
      low_c[s] = low_q[s-1];
      quo_c[s] = quo_q[s-1];
      den_c[s] = den_q[s-1];
    end
    for (int s = 0; s < DW; s++) begin
      trial = {rem_c[s], low_c[s][DW-1]};
      diff  = trial - {1'b0, den_c[s]};
      if (trial >= {1'b0, den_c[s]}) begin
        rem_d[s] = diff[DW-1:0];
        quo_d[s] = {quo_c[s][DW-2:0], 1'b1};
      end else begin
        rem_d[s] = trial[DW-1:0];
        quo_d[s] = {quo_c[s][DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DW; s++) begin
      rem_q[s] <= rem_d[s];
      low_q[s] <= {low_c[s][DW-2:0], 1'b0};
      quo_q[s] <= quo_d[s];
      den_q[s] <= den_c[s];
    end
  end

  assign quot_o.quo  = quo_q[DW-1];
  assign quot_o.frac = (rem_q[DW-1] != '0);

endmodule

// ===== hw/rtl/lsrc_select.sv =====
// ----------------------------------------------------------------------------
// lsrc_select
// Turns quotients into crossings, merges duplicates and picks the result ends.
// ----------------------------------------------------------------------------
module lsrc_select (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  lsrc_pkg::side_t                           side_i,
  input  lsrc_pkg::quot_t [lsrc_pkg::NumEdges-1:0]  quot_i,
  output logic                                      valid_o,
  output lsrc_pkg::out_item_t                       item_o
);

  localparam int unsigned CW = lsrc_pkg::CoordWidth;
  localparam int unsigned NE = lsrc_pkg::NumEdges;

  logic              va_q, vb_q, vc_q, vd_q;
  lsrc_pkg::side_t   sa_q, sb_q;
  logic [NE-1:0]     cv_d, cv_q, uq_d, uq_q;
  lsrc_pkg::coord_t  cx_d [NE];
  lsrc_pkg::coord_t  cy_d [NE];
  lsrc_pkg::coord_t  cx_q [NE];
  lsrc_pkg::coord_t  cy_q [NE];
  lsrc_pkg::coord_t  bx_q [NE];
  lsrc_pkg::coord_t  by_q [NE];
  lsrc_pkg::dist_t   ds_d [NE];
  lsrc_pkg::dist_t   ds_q [NE];
  lsrc_pkg::out_item_t oc_d, oc_q, od_d, od_q;
  lsrc_pkg::in_item_t  ic_q;

  // Crossing value: base plus or minus the quotient, rounded toward zero.
  always_comb begin
    lsrc_pkg::sol_t   fl, qs, tr, lo, hi, bs;
    lsrc_pkg::coord_t edge_c;
    for (int k = 0; k < NE; k++) begin
      if (k < 2) begin
        bs = lsrc_pkg::sol_t'(side_i.y0);
        lo = lsrc_pkg::sol_t'(side_i.win.ylo);
        hi = lsrc_pkg::sol_t'(side_i.win.yhi);
        edge_c = (k == 0) ? side_i.win.xlo : side_i.win.xhi;
      end else begin
        bs = lsrc_pkg::sol_t'(side_i.x0);
        lo = lsrc_pkg::sol_t'(side_i.win.xlo);
        hi = lsrc_pkg::sol_t'(side_i.win.xhi);
        edge_c = (k == 2) ? side_i.win.ylo : side_i.win.yhi;
      end
      qs = lsrc_pkg::sol_t'({2'b00, quot_i[k].quo});
      if (side_i.neg[k]) begin
        qs = -qs - lsrc_pkg::sol_t'({1'b0, quot_i[k].frac});
      end
      fl = bs + qs;
      tr = (quot_i[k].frac && fl < 0) ? fl + lsrc_pkg::sol_t'(1) : fl;
      cv_d[k] = side_i.ok[k] && (fl >= lo) &&
                ((fl < hi) || ((fl == hi) && !quot_i[k].frac));
      cx_d[k] = (k < 2) ? edge_c : tr[CW-1:0];
      cy_d[k] = (k < 2) ? tr[CW-1:0] : edge_c;
    end
  end

  // Duplicate corner hits and distances from the start point.
  always_comb begin
    logic dup;
    for (int k = 0; k < NE; k++) begin
      dup = 1'b0;
      for (int j = 0; j < k; j++) begin
        if (cv_q[j] && cx_q[j] == cx_q[k] && cy_q[j] == cy_q[k]) begin
          dup = 1'b1;
        end
      end
      uq_d[k] = cv_q[k] && !dup;
      ds_d[k] = lsrc_pkg::dist_t'(lsrc_pkg::mag_of({cx_q[k][CW-1], cx_q[k]} -
                                                   {sa_q.x0[CW-1], sa_q.x0})) +
                lsrc_pkg::dist_t'(lsrc_pkg::mag_of({cy_q[k][CW-1], cy_q[k]} -
                                                   {sa_q.y0[CW-1], sa_q.y0}));
    end
  end

  // Nearest and farthest crossing, and from them the result ends; earlier edges win ties.
  always_comb begin
    logic            have;
    logic [1:0]      near, far;
    lsrc_pkg::dist_t dn, df;
    logic [2:0]      cnt;
    have = 1'b0;
    near = '0;
    far  = '0;
    dn   = '0;
    df   = '0;
    cnt  = '0;
    for (int k = 0; k < NE; k++) begin
      if (uq_q[k]) begin
        cnt = cnt + 3'd1;
        if (!have || ds_q[k] < dn) begin
          dn = ds_q[k];
          near = 2'(k);
        end
        if (!have || ds_q[k] > df) begin
          df = ds_q[k];
          far = 2'(k);
        end
        have = 1'b1;
      end
    end
    oc_d = '0;
    if (sb_q.in0 && sb_q.in1) begin
      oc_d.visible     = 1'b1;
      oc_d.out_start_x = sb_q.x0;
      oc_d.out_start_y = sb_q.y0;
      oc_d.out_end_x   = sb_q.x1;
      oc_d.out_end_y   = sb_q.y1;
    end else if (cnt == 3'd1) begin
      oc_d.visible     = 1'b1;
      oc_d.out_start_x = sb_q.in0 ? sb_q.x0 : bx_q[near];
      oc_d.out_start_y = sb_q.in0 ? sb_q.y0 : by_q[near];
      oc_d.out_end_x   = (!sb_q.in0 && sb_q.in1) ? sb_q.x1 : bx_q[near];
      oc_d.out_end_y   = (!sb_q.in0 && sb_q.in1) ? sb_q.y1 : by_q[near];
    end else if (cnt != 3'd0) begin
      oc_d.visible     = 1'b1;
      oc_d.out_start_x = bx_q[near];
      oc_d.out_start_y = by_q[near];
      oc_d.out_end_x   = bx_q[far];
      oc_d.out_end_y   = by_q[far];
    end
  end

  always_comb begin
    od_d = oc_q;
    od_d.was_clipped = oc_q.visible &&
                       ((oc_q.out_start_x != ic_q.start_x) ||
                        (oc_q.out_start_y != ic_q.start_y) ||
                        (oc_q.out_end_x   != ic_q.end_x) ||
                        (oc_q.out_end_y   != ic_q.end_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q <= side_i;
    cv_q <= cv_d;
    sb_q <= sa_q;
    uq_q <= uq_d;
    for (int k = 0; k < NE; k++) begin
      cx_q[k] <= cx_d[k];
      cy_q[k] <= cy_d[k];
      bx_q[k] <= cx_q[k];
      by_q[k] <= cy_q[k];
      ds_q[k] <= ds_d[k];
    end
    oc_q <= oc_d;
    ic_q.start_x <= sb_q.x0;
    ic_q.start_y <= sb_q.y0;
    ic_q.end_x   <= sb_q.x1;
    ic_q.end_y   <= sb_q.y1;
    od_q <= od_d;
  end

  assign valid_o = vd_q;
  assign item_o  = od_q;

endmodule

// ===== hw/rtl/line_segment_rect_clipper.sv =====
// ----------------------------------------------------------------------------
// line_segment_rect_clipper
// Clips a line segment against an axis-aligned window held in four registers.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                     Payload
//   -------   ---------------------------   ------------------------------
//   input     start_i high, busy_o low      item_i (segment end points)
//   result    result_valid_o, one cycle     result_o (clipped segment)
//   config    cfg_we_i                      cfg_idx_i, cfg_data_i
//
// One item may be taken in every cycle; busy_o is always low. Each result
// passes two set-up stages (edge tests, then the 17 by 17 bit products),
// seventeen divider stages that each retire one quotient bit, and four
// stages that form, merge and pick the crossings. The receiver cannot stall,
// so every stage advances on every clock. Reset clears the valid bits and
// loads the default window; the data registers are not reset.
module line_segment_rect_clipper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  lsrc_pkg::in_item_t          item_i,
  output logic                        result_valid_o,
  output lsrc_pkg::out_item_t         result_o,
  input  logic                        cfg_we_i,
  input  lsrc_pkg::cfg_idx_e          cfg_idx_i,
  input  lsrc_pkg::coord_t            cfg_data_i
);

  localparam int unsigned DW = lsrc_pkg::DiffWidth;
  localparam int unsigned NE = lsrc_pkg::NumEdges;

  lsrc_pkg::coord_t left_q, right_q, top_q, bottom_q;
  lsrc_pkg::window_t win;

  logic                                  setup_valid;
  lsrc_pkg::side_t                       setup_side;
  lsrc_pkg::lane_t [NE-1:0]              setup_lane;
  lsrc_pkg::quot_t [NE-1:0]              quot;

  // The item data rides beside the divider in a delay line of equal depth.
  logic            dvalid_q [DW];
  lsrc_pkg::side_t dside_q  [DW];

  // Configuration registers. They must be written only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= lsrc_pkg::coord_t'(0);
      right_q  <= lsrc_pkg::coord_t'(1023);
      top_q    <= lsrc_pkg::coord_t'(0);
      bottom_q <= lsrc_pkg::coord_t'(1023);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsrc_pkg::CfgLeft:   left_q   <= cfg_data_i;
        lsrc_pkg::CfgRight:  right_q  <= cfg_data_i;
        lsrc_pkg::CfgTop:    top_q    <= cfg_data_i;
        lsrc_pkg::CfgBottom: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Swapped bounds are allowed, so the window is put in order here.
  assign win.xlo = (left_q < right_q)  ? left_q   : right_q;
  assign win.xhi = (left_q < right_q)  ? right_q  : left_q;
  assign win.ylo = (top_q  < bottom_q) ? top_q    : bottom_q;
  assign win.yhi = (top_q  < bottom_q) ? bottom_q : top_q;

  assign busy_o = 1'b0;

  lsrc_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .item_i  (item_i),
    .win_i   (win),
    .valid_o (setup_valid),
    .side_o  (setup_side),
    .lane_o  (setup_lane)
  );

  // One divider per window edge: each gives the distance along the other
  // axis from the start point to that edge's crossing.
  for (genvar k = 0; k < NE; k++) begin : g_lane
    lsrc_div u_div (
      .clk_i  (clk_i),
      .lane_i (setup_lane[k]),
      .quot_o (quot[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DW; s++) begin
        dvalid_q[s] <= 1'b0;
      end
    end else begin
      dvalid_q[0] <= setup_valid;
      for (int s = 1; s < DW; s++) begin
        dvalid_q[s] <= dvalid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dside_q[0] <= setup_side;
    for (int s = 1; s < DW; s++) begin
      dside_q[s] <= dside_q[s-1];
    end
  end

  lsrc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dvalid_q[DW-1]),
    .side_i  (dside_q[DW-1]),
    .quot_i  (quot),
    .valid_o (result_valid_o),
    .item_o  (result_o)
  );

`ifndef SYNTHESIS
  // A hidden segment reports all zeros.
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.visible) |->
      (!result_o.was_clipped && result_o.out_start_x == '0 &&
       result_o.out_start_y == '0 && result_o.out_end_x == '0 &&
       result_o.out_end_y == '0))
    else $error("hidden segment with nonzero result fields");

  // Clipping only happens to a visible segment.
  a_clip_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.was_clipped) |-> result_o.visible)
    else $error("clipped flag set on a hidden segment");

  // A valid bit that enters the divider delay line is passed on to its second entry.
  a_line_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dvalid_q[0]) |=> dvalid_q[1])
    else $error("valid bit lost in the divider delay line");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line segment rectangle clipper. Segments are
// sent, with random gaps in the random phases, each result is compared
// field by field with a local model of the clipping rules, and the clip
// window is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Depth of the pipeline from a taken item to its result, used by drain().
  localparam int PipeDepth = 23;
  // Cycles without any accepted item, result or window write before the run is abandoned.
  localparam int StallLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  lsrc_pkg::in_item_t  item_i = '0;
  logic                result_valid_o;
  lsrc_pkg::out_item_t result_o;
  logic                cfg_we_i = 1'b0;
  lsrc_pkg::cfg_idx_e  cfg_idx_i = lsrc_pkg::CfgLeft;
  lsrc_pkg::coord_t    cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  line_segment_rect_clipper dut (.*);

  // Window registers as the block should hold them.
  longint              win_reg [4];
  lsrc_pkg::out_item_t clipped_q[$];
  int                  mismatch_cnt = 0;
  int                  idle_cycles = 0;

  // Exact value base + a*b/den split into floor and a flag for a remainder.
  // All operands stay below 2^18, so a longint product cannot overflow.
  function automatic void crossing_at(input longint base, num_a, num_b, den,
                                      output longint fl, output bit frac);
    longint p, q, r;
    p = num_a * num_b;
    if (den < 0) begin
      p = -p;
      den = -den;
    end
    q = p / den;
    r = p % den;
    if (r < 0) q = q - 1;
    fl = base + q;
    frac = (r != 0);
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic lsrc_pkg::out_item_t clip_segment(lsrc_pkg::in_item_t it);
    lsrc_pkg::out_item_t res;
    longint x0, y0, x1, y1, xlo, xhi, ylo, yhi, dx, dy, edge_pos, fl, px, py;
    longint cx[4], cy[4], d, dn, df;
    longint ox0, oy0, ox1, oy1;
    longint wl, wr, wt, wb;
    bit frac, dup, in0, in1, vis;
    int n, near_i, far_i;
    x0 = longint'(it.start_x); y0 = longint'(it.start_y);
    x1 = longint'(it.end_x);   y1 = longint'(it.end_y);
    wl = win_reg[lsrc_pkg::CfgLeft];
    wr = win_reg[lsrc_pkg::CfgRight];
    wt = win_reg[lsrc_pkg::CfgTop];
    wb = win_reg[lsrc_pkg::CfgBottom];
    // Bounds given the wrong way round are taken as their min and max.
    xlo = wl < wr ? wl : wr;
    xhi = wl < wr ? wr : wl;
    ylo = wt < wb ? wt : wb;
    yhi = wt < wb ? wb : wt;
    dx = x1 - x0; dy = y1 - y0;
    in0 = x0 >= xlo && x0 <= xhi && y0 >= ylo && y0 <= yhi;
    in1 = x1 >= xlo && x1 <= xhi && y1 >= ylo && y1 <= yhi;
    n = 0; vis = 0; ox0 = 0; oy0 = 0; ox1 = 0; oy1 = 0;
    if (in0 && in1) begin
      vis = 1; ox0 = x0; oy0 = y0; ox1 = x1; oy1 = y1;
    end else begin
      // Edges in the order left, right, top, bottom.
      for (int e = 0; e < 4; e++) begin
        edge_pos = (e == 0) ? xlo : (e == 1) ? xhi : (e == 2) ? ylo : yhi;
        if (e < 2) begin
          if (dx == 0 || edge_pos < (x0 < x1 ? x0 : x1) || edge_pos > (x0 > x1 ? x0 : x1))
            continue;
          crossing_at(y0, edge_pos - x0, dy, dx, fl, frac);
          if (!(fl >= ylo && (fl < yhi || (fl == yhi && !frac)))) continue;
          px = edge_pos; py = (frac && fl < 0) ? fl + 1 : fl;
        end else begin
          if (dy == 0 || edge_pos < (y0 < y1 ? y0 : y1) || edge_pos > (y0 > y1 ? y0 : y1))
            continue;
          crossing_at(x0, edge_pos - y0, dx, dy, fl, frac);
          if (!(fl >= xlo && (fl < xhi || (fl == xhi && !frac)))) continue;
          px = (frac && fl < 0) ? fl + 1 : fl; py = edge_pos;
        end
        // A corner hit by both of its edges counts as a single crossing.
        dup = 0;
        for (int k = 0; k < n; k++) if (cx[k] == px && cy[k] == py) dup = 1;
        if (!dup) begin
          cx[n] = px; cy[n] = py; n++;
        end
      end
      if (n == 1) begin
        vis = 1;
        if (in0) begin
          ox0 = x0; oy0 = y0; ox1 = cx[0]; oy1 = cy[0];
        end else if (in1) begin
          ox0 = cx[0]; oy0 = cy[0]; ox1 = x1; oy1 = y1;
        end else begin
          ox0 = cx[0]; oy0 = cy[0]; ox1 = cx[0]; oy1 = cy[0];
        end
      end else if (n >= 2) begin
        near_i = 0; far_i = 0;
        dn = labs(cx[0] - x0) + labs(cy[0] - y0); df = dn;
        for (int k = 1; k < n; k++) begin
          d = labs(cx[k] - x0) + labs(cy[k] - y0);
          if (d < dn) begin
            dn = d; near_i = k;
          end
          if (d > df) begin
            df = d; far_i = k;
          end
        end
        vis = 1;
        ox0 = cx[near_i]; oy0 = cy[near_i]; ox1 = cx[far_i]; oy1 = cy[far_i];
      end
    end
    res.visible = vis;
    res.was_clipped = vis && (ox0 != x0 || oy0 != y0 || ox1 != x1 || oy1 != y1);
    res.out_start_x = lsrc_pkg::coord_t'(ox0); res.out_start_y = lsrc_pkg::coord_t'(oy0);
    res.out_end_x = lsrc_pkg::coord_t'(ox1);   res.out_end_y = lsrc_pkg::coord_t'(oy1);
    return res;
  endfunction

  // Half the time no gap, otherwise mostly a short one and now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item; the expectation is queued at the edge that takes it.
  // start stays high after acceptance so that the next item can follow in
  // the very next cycle; a gap or drain() lowers it.
  task automatic send_segment(lsrc_pkg::in_item_t it, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    clipped_q.push_back(clip_segment(it));
  endtask

  // Lowers start after the last item and waits until the pipeline is empty.
  task automatic drain();
    start_i <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic write_window(lsrc_pkg::cfg_idx_e idx, lsrc_pkg::coord_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg[idx] = longint'(val);
  endtask

  task automatic set_window(lsrc_pkg::coord_t l, lsrc_pkg::coord_t r,
                            lsrc_pkg::coord_t t, lsrc_pkg::coord_t b);
    write_window(lsrc_pkg::CfgLeft, l);
    write_window(lsrc_pkg::CfgRight, r);
    write_window(lsrc_pkg::CfgTop, t);
    write_window(lsrc_pkg::CfgBottom, b);
  endtask

  function automatic lsrc_pkg::in_item_t seg(int x0, int y0, int x1, int y1);
    lsrc_pkg::in_item_t it;
    it.start_x = lsrc_pkg::coord_t'(x0); it.start_y = lsrc_pkg::coord_t'(y0);
    it.end_x = lsrc_pkg::coord_t'(x1);   it.end_y = lsrc_pkg::coord_t'(y1);
    return it;
  endfunction

  // Corner cases against the reset window [0,1023] x [0,1023].
  task automatic test_directed();
    send_segment(seg(10, 20, 500, 600), 0);          // wholly inside
    send_segment(seg(-100, 50, 2000, 50), 0);        // crosses both sides
    send_segment(seg(100, 100, 2000, 900), 0);       // start inside only
    send_segment(seg(-500, 300, 400, 700), 0);       // end inside only
    send_segment(seg(-10, -10, 1100, 1100), 0);      // diagonal through corners
    send_segment(seg(-10, 10, 10, -10), 0);          // touches a corner only
    send_segment(seg(-100, -100, -50, 2000), 0);     // misses the window
    send_segment(seg(2000, 2000, 2000, 2000), 0);    // point outside
    send_segment(seg(500, 500, 500, 500), 0);        // point inside
    send_segment(seg(0, -50, 0, 2000), 0);           // along the left edge
    send_segment(seg(-50, 1023, 2000, 1023), 0);     // along the bottom edge
    send_segment(seg(-32768, -32768, 32767, 32767), 0);
    send_segment(seg(32767, -32768, -32768, 32767), 0);
    send_segment(seg(-32768, 7, 32767, 3), 0);       // rounding toward zero
    send_segment(seg(3, -32768, -7, 32767), 0);
    send_segment(seg(1023, 1023, 1500, 1400), 0);    // start on a corner
    send_segment(seg(2000, 500, 500, 500), 0);       // leftward, end inside
    send_segment(seg(-1, 0, 1024, 1), 0);
    drain();
  endtask

  // Bounds given the wrong way round, and the widest and a one-point window.
  task automatic test_window_extremes();
    set_window(16'sd1023, 16'sd0, 16'sd1023, 16'sd0);
    send_segment(seg(-100, 50, 2000, 50), 0);
    send_segment(seg(-10, -10, 1100, 1100), 0);
    drain();
    set_window(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_segment(seg(-32768, -32768, 32767, 32767), 0);
    send_segment(seg(-5, 9, 32767, -32768), 0);
    drain();
    set_window(-16'sd7, -16'sd7, 16'sd5, 16'sd5);
    send_segment(seg(-100, 5, 100, 5), 0);
    send_segment(seg(-100, -95, 86, 91), 0);
    send_segment(seg(-7, 5, -7, 5), 0);
    drain();
  endtask

  function automatic lsrc_pkg::coord_t rnd_coord(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lsrc_pkg::coord_t'($urandom());         // any value
    if (r == 1) return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    return lsrc_pkg::coord_t'($urandom_range(0, hi - lo) + lo);
  endfunction

  // Random segments against a random window; most lie around the window so
  // that every way of crossing it is common.
  task automatic test_random_phase(int count);
    int a, b, c, e, lo, hi;
    a = $urandom_range(0, 65535) - 32768;
    b = a + $urandom_range(0, 4000);
    if (b > 32767) b = 32767;
    c = $urandom_range(0, 65535) - 32768;
    e = c + $urandom_range(0, 4000);
    if (e > 32767) e = 32767;
    if ($urandom_range(0, 3) == 0)
      set_window(lsrc_pkg::coord_t'(b), lsrc_pkg::coord_t'(a),
                 lsrc_pkg::coord_t'(e), lsrc_pkg::coord_t'(c));
    else
      set_window(lsrc_pkg::coord_t'(a), lsrc_pkg::coord_t'(b),
                 lsrc_pkg::coord_t'(c), lsrc_pkg::coord_t'(e));
    lo = (a < c ? a : c) - 3000;
    hi = (b > e ? b : e) + 3000;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    for (int i = 0; i < count; i++) begin
      send_segment(seg(rnd_coord(lo, hi), rnd_coord(lo, hi),
                       rnd_coord(lo, hi), rnd_coord(lo, hi)), 1);
    end
    drain();
  endtask

  // Compares each result with the oldest expectation.
  always @(posedge clk_i) begin
    lsrc_pkg::out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (clipped_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result %h", result_o);
      end else begin
        want = clipped_q.pop_front();
        if (result_o.visible !== want.visible ||
            result_o.was_clipped !== want.was_clipped ||
            result_o.out_start_x !== want.out_start_x ||
            result_o.out_start_y !== want.out_start_y ||
            result_o.out_end_x !== want.out_end_x ||
            result_o.out_end_y !== want.out_end_y) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch: expected %h, got %h", want, result_o);
        end
      end
    end
  end

  // Watchdog: counts cycles with no item taken, no result and no window write.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    win_reg[lsrc_pkg::CfgLeft] = 0;
    win_reg[lsrc_pkg::CfgRight] = 1023;
    win_reg[lsrc_pkg::CfgTop] = 0;
    win_reg[lsrc_pkg::CfgBottom] = 1023;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_window_extremes();
    for (int p = 0; p < 10; p++) test_random_phase(100);
    if (clipped_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
